// ===== hdl/tcch_pkg.sv =====
package tcch_pkg;

    // Field widths of the channels
    localparam int SAMPLE_W  = 16;
    localparam int HEADING_W = 9;
    localparam int FINE_W    = 17;
    localparam int SHIFT_W   = 4;

    // Defaults for the top-level parameters
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Datapath widths
    localparam int CORDIC_W = 24;   // CORDIC x/y working width
    localparam int ANG_W    = 20;   // angle, signed degrees Q9.8
    localparam int ROT_W    = 18;   // rotated samples
    localparam int TRIG_W   = 16;   // sin/cos, Q1.15
    localparam int LUT_IDX_W = 5;
    localparam int TABLE_LEN = 24;

    // Angle constants in degrees Q9.8
    localparam logic signed [ANG_W-1:0] DEG90  = 20'sd23040;
    localparam logic signed [ANG_W-1:0] DEG180 = 20'sd46080;
    localparam logic signed [CORDIC_W-1:0] INV_GAIN = 24'sd19899;
    localparam int Q15_RND     = 32767;
    localparam int HEADING_MOD = 360;
    localparam int SHIFT_MAX   = 8;
    localparam int FINE_MAX    = 91904;

    // Configuration registers
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_OFFSET = 1'b0;
    localparam logic REG_SHIFT  = 1'b1;
    localparam logic [HEADING_W-1:0] OFFSET_RST = 9'd166;
    localparam logic [SHIFT_W-1:0]   SHIFT_RST  = 4'd3;

    // Rotation selects for the shared multiplier
    localparam logic [1:0] ROT_MY2 = 2'd0;
    localparam logic [1:0] ROT_MZ2 = 2'd1;
    localparam logic [1:0] ROT_AZ2 = 2'd2;
    localparam logic [1:0] ROT_MX2 = 2'd3;

    // Multiply-accumulate phases
    localparam logic [1:0] MAC_PH_FIRST  = 2'd0;
    localparam logic [1:0] MAC_PH_SECOND = 2'd1;
    localparam logic [1:0] MAC_PH_SUM    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROLL_VEC,
        ST_ROLL_ROT,
        ST_MAC,
        ST_PITCH_VEC,
        ST_PITCH_ROT,
        ST_HEAD_VEC,
        ST_HEADING,
        ST_SMOOTH,
        ST_DONE
    } tcch_state_t;

    // atan(2^-i) in degrees Q9.8, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [LUT_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 20'sd11520;
                5'd1:    val = 20'sd6801;
                5'd2:    val = 20'sd3593;
                5'd3:    val = 20'sd1824;
                5'd4:    val = 20'sd916;
                5'd5:    val = 20'sd458;
                5'd6:    val = 20'sd229;
                5'd7:    val = 20'sd115;
                5'd8:    val = 20'sd57;
                5'd9:    val = 20'sd29;
                5'd10:   val = 20'sd14;
                5'd11:   val = 20'sd7;
                5'd12:   val = 20'sd4;
                5'd13:   val = 20'sd2;
                5'd14:   val = 20'sd1;
                default: val = 20'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== hdl/tcch_if.sv =====
interface tcch_sensor_if import tcch_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] acc_x;
    logic signed [SAMPLE_W-1:0] acc_y;
    logic signed [SAMPLE_W-1:0] acc_z;
    logic signed [SAMPLE_W-1:0] mag_x;
    logic signed [SAMPLE_W-1:0] mag_y;
    logic signed [SAMPLE_W-1:0] mag_z;

    modport source (
        output valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z,
        input  ready
    );
    modport sink (
        input  valid, acc_x, acc_y, acc_z, mag_x, mag_y, mag_z,
        output ready
    );
endinterface

interface tcch_result_if import tcch_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [HEADING_W-1:0] raw_heading;
    logic [FINE_W-1:0]    smoothed_heading_fine;
    logic [HEADING_W-1:0] smoothed_heading;

    modport source (
        output valid, raw_heading, smoothed_heading_fine, smoothed_heading,
        input  ready
    );
    modport sink (
        input  valid, raw_heading, smoothed_heading_fine, smoothed_heading,
        output ready
    );
endinterface

// ===== hdl/tilt_compensated_compass_heading.sv =====
// A vectoring pass with a zero y operand skips its micro-rotations. Each transaction makes
// five passes through the single CORDIC stage plus four two-term products on one multiplier;
// a new transaction is taken only once the last result has moved to the output register.
// The output register lets a finished result wait while the next transaction is taken.
// Reset (rst_n, asynchronous, active low) clears the smoothing state and the handshakes,
// and loads offset_reg = 166, shift_reg = 3.
module tilt_compensated_compass_heading import tcch_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcch_sensor_if.sink           sensor,
    tcch_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam int MW    = ROT_W + TRIG_W;
    localparam int MS    = MW + 1;
    localparam int HQ_W  = ANG_W + 1;
    localparam int HT_W  = HQ_W - 8;
    localparam int DF_W  = FINE_W + 1;

    tcch_state_t state_reg, state_next;

    logic [HEADING_W-1:0] offset_reg;
    logic [SHIFT_W-1:0]   shift_reg;

    logic signed [SAMPLE_BITS-1:0] ax_reg, ay_reg, az_reg, mx_reg, my_reg, mz_reg;
    logic signed [SAMPLE_BITS-1:0] ax_next, ay_next, az_next, mx_next, my_next, mz_next;

    logic signed [CORDIC_W-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic signed [ANG_W-1:0]    cz_reg, cz_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       cneg_reg, cneg_next;

    logic signed [TRIG_W-1:0] sin_reg, cos_reg, sin_next, cos_next;
    logic signed [ROT_W-1:0]  my2_reg, mz2_reg, my2_next, mz2_next;
    logic [1:0]               rot_reg, rot_next;
    logic [1:0]               ph_reg, ph_next;
    logic signed [MW-1:0]     prod_reg, acc_reg, prod_next, acc_next;

    logic [HEADING_W-1:0] head_reg, head_next;
    logic [FINE_W-1:0]    prev_reg, prev_next;

    logic                 out_valid_reg, out_valid_next;
    logic [HEADING_W-1:0] out_raw_reg, out_raw_next;
    logic [FINE_W-1:0]    out_fine_reg, out_fine_next;

    logic cnt_end;
    logic out_free;

    // Configuration port: zero wait states, register picked by paddr bit 2
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RST;
            shift_reg  <= SHIFT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_OFFSET: offset_reg <= pwdata[HEADING_W-1:0];
                REG_SHIFT:  shift_reg  <= pwdata[SHIFT_W-1:0];
                default:    offset_reg <= offset_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_OFFSET: prdata = APB_DATA_W'(offset_reg);
            REG_SHIFT:  prdata = APB_DATA_W'(shift_reg);
            default:    prdata = '0;
        endcase
    end

    assign cnt_end  = (cnt_reg == CNT_W'(CORDIC_STEPS));
    assign out_free = !out_valid_reg || result.ready;

    // Shared CORDIC stage: one micro-rotation per cycle
    logic signed [CORDIC_W-1:0] xs, ys, step_x, step_y;
    logic signed [ANG_W-1:0]    step_at, step_z;
    logic                       rot_mode, step_dn;

    always_comb
    begin
        xs       = cx_reg >>> cnt_reg;
        ys       = cy_reg >>> cnt_reg;
        step_at  = atan_lut(LUT_IDX_W'(cnt_reg));
        rot_mode = (state_reg == ST_ROLL_ROT) || (state_reg == ST_PITCH_ROT);
        step_dn  = rot_mode ? !cz_reg[ANG_W-1] : cy_reg[CORDIC_W-1];
        if (step_dn)
        begin
            step_x = cx_reg - ys;
            step_y = cy_reg + xs;
            step_z = cz_reg - step_at;
        end
        else
        begin
            step_x = cx_reg + ys;
            step_y = cy_reg - xs;
            step_z = cz_reg + step_at;
        end
    end

    // Shared multiplier and two-term accumulate with truncation toward zero
    logic signed [ROT_W-1:0]  t0a, t1a, mul_a;
    logic signed [TRIG_W-1:0] t0b, t1b, mul_b;
    logic                     mac_sub;
    logic signed [MW-1:0]     mul_p;
    logic signed [MS-1:0]     mac_sum, mac_tr;
    logic signed [ROT_W-1:0]  mac_res;

    always_comb
    begin
        mac_sub = 1'b0;
        case (rot_reg)
            ROT_MY2:
            begin
                t0a = ROT_W'(my_reg); t0b = cos_reg;
                t1a = ROT_W'(mz_reg); t1b = sin_reg;
                mac_sub = 1'b1;
            end
            ROT_MZ2:
            begin
                t0a = ROT_W'(my_reg); t0b = sin_reg;
                t1a = ROT_W'(mz_reg); t1b = cos_reg;
            end
            ROT_AZ2:
            begin
                t0a = ROT_W'(ay_reg); t0b = sin_reg;
                t1a = ROT_W'(az_reg); t1b = cos_reg;
            end
            default:
            begin
                t0a = ROT_W'(mx_reg); t0b = cos_reg;
                t1a = mz2_reg;        t1b = sin_reg;
            end
        endcase
        mul_a   = (ph_reg == MAC_PH_FIRST) ? t0a : t1a;
        mul_b   = (ph_reg == MAC_PH_FIRST) ? t0b : t1b;
        mul_p   = MW'(mul_a) * MW'(mul_b);
        mac_sum = mac_sub ? (MS'(acc_reg) - MS'(prod_reg)) : (MS'(acc_reg) + MS'(prod_reg));
        mac_tr  = (mac_sum + (mac_sum[MS-1] ? MS'(Q15_RND) : MS'(0))) >>> 15;
        mac_res = ROT_W'(mac_tr);
    end

    // Vectoring load: pick the atan2 operands and handle the axis cases
    logic signed [CORDIC_W-1:0] vin_y, vin_x, vl_x, vl_y;
    logic signed [ANG_W-1:0]    vl_z;
    logic [CNT_W-1:0]           vl_cnt;

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            vin_y = CORDIC_W'(signed'(sensor.acc_y[SAMPLE_BITS-1:0]));
            vin_x = CORDIC_W'(signed'(sensor.acc_z[SAMPLE_BITS-1:0]));
        end
        else if (rot_reg == ROT_AZ2)
        begin
            vin_y = -CORDIC_W'(ax_reg);
            vin_x = CORDIC_W'(mac_res);
        end
        else
        begin
            vin_y = CORDIC_W'(my2_reg);
            vin_x = CORDIC_W'(mac_res);
        end

        vl_x   = vin_x;
        vl_y   = vin_y;
        vl_cnt = '0;
        if (vin_y == '0)
        begin
            vl_z   = vin_x[CORDIC_W-1] ? DEG180 : '0;
            vl_cnt = CNT_W'(CORDIC_STEPS);
        end
        else if (vin_x[CORDIC_W-1])
        begin
            vl_z = vin_y[CORDIC_W-1] ? -DEG180 : DEG180;
            vl_x = -vin_x;
            vl_y = -vin_y;
        end
        else
        begin
            vl_z = '0;
        end
    end

    // Rotation load: fold the angle into +-90 degrees
    logic signed [ANG_W-1:0] sl_z;
    logic                    sl_neg;

    always_comb
    begin
        sl_z   = cz_reg;
        sl_neg = 1'b0;
        if (cz_reg > DEG90)
        begin
            sl_z   = cz_reg - DEG180;
            sl_neg = 1'b1;
        end
        else if (cz_reg < -DEG90)
        begin
            sl_z   = cz_reg + DEG180;
            sl_neg = 1'b1;
        end
    end

    function automatic logic signed [TRIG_W-1:0] sat_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [TRIG_W-1:0] r;
        begin
            if (v > CORDIC_W'(32767))
                r = 16'sh7FFF;
            else if (v < -CORDIC_W'(32768))
                r = 16'sh8000;
            else
                r = TRIG_W'(v);
            return r;
        end
    endfunction

    // Heading: offset minus angle, truncate to degrees, wrap into 0..359
    logic signed [HQ_W-1:0] hq8, hq_adj;
    logic signed [HT_W-1:0] h_deg, h_pos;
    logic signed [HT_W-1:0] h_mod;

    always_comb
    begin
        hq8    = HQ_W'($signed({1'b0, offset_reg, 8'b0})) - HQ_W'(cz_reg);
        hq_adj = hq8 + (hq8[HQ_W-1] ? HQ_W'(255) : HQ_W'(0));
        h_deg  = HT_W'(hq_adj >>> 8);
        h_pos  = h_deg[HT_W-1] ? (h_deg + HT_W'(2 * HEADING_MOD)) : h_deg;
        if (h_pos >= HT_W'(2 * HEADING_MOD))
            h_mod = h_pos - HT_W'(2 * HEADING_MOD);
        else if (h_pos >= HT_W'(HEADING_MOD))
            h_mod = h_pos - HT_W'(HEADING_MOD);
        else
            h_mod = h_pos;
    end

    // Smoothing: prev + floor((target - prev) / 2^k), k saturated at 8
    logic [SHIFT_W-1:0]     k_sat;
    logic signed [DF_W-1:0] sm_diff, sm_step, sm_sum;

    always_comb
    begin
        k_sat   = (shift_reg > SHIFT_W'(SHIFT_MAX)) ? SHIFT_W'(SHIFT_MAX) : shift_reg;
        sm_diff = $signed({1'b0, head_reg, 8'b0}) - $signed({1'b0, prev_reg});
        sm_step = sm_diff >>> k_sat;
        sm_sum  = $signed({1'b0, prev_reg}) + sm_step;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (sensor.valid) state_next = ST_ROLL_VEC;
            ST_ROLL_VEC:  if (cnt_end) state_next = ST_ROLL_ROT;
            ST_ROLL_ROT:  if (cnt_end) state_next = ST_MAC;
            ST_MAC:
            begin
                if (ph_reg == MAC_PH_SUM)
                begin
                    if (rot_reg == ROT_AZ2)
                        state_next = ST_PITCH_VEC;
                    else if (rot_reg == ROT_MX2)
                        state_next = ST_HEAD_VEC;
                end
            end
            ST_PITCH_VEC: if (cnt_end) state_next = ST_PITCH_ROT;
            ST_PITCH_ROT: if (cnt_end) state_next = ST_MAC;
            ST_HEAD_VEC:  if (cnt_end) state_next = ST_HEADING;
            ST_HEADING:   state_next = ST_SMOOTH;
            ST_SMOOTH:    state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath updates per state
    always_comb
    begin
        ax_next = ax_reg; ay_next = ay_reg; az_next = az_reg;
        mx_next = mx_reg; my_next = my_reg; mz_next = mz_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        cnt_next  = cnt_reg;
        cneg_next = cneg_reg;
        sin_next  = sin_reg;
        cos_next  = cos_reg;
        my2_next  = my2_reg;
        mz2_next  = mz2_reg;
        rot_next  = rot_reg;
        ph_next   = ph_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        head_next = head_reg;
        prev_next = prev_reg;
        out_raw_next   = out_raw_reg;
        out_fine_next  = out_fine_reg;
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the transaction and start the roll atan2
                if (sensor.valid)
                begin
                    ax_next = signed'(sensor.acc_x[SAMPLE_BITS-1:0]);
                    ay_next = signed'(sensor.acc_y[SAMPLE_BITS-1:0]);
                    az_next = signed'(sensor.acc_z[SAMPLE_BITS-1:0]);
                    mx_next = signed'(sensor.mag_x[SAMPLE_BITS-1:0]);
                    my_next = signed'(sensor.mag_y[SAMPLE_BITS-1:0]);
                    mz_next = signed'(sensor.mag_z[SAMPLE_BITS-1:0]);
                    cx_next  = vl_x;
                    cy_next  = vl_y;
                    cz_next  = vl_z;
                    cnt_next = vl_cnt;
                    rot_next = ROT_MY2;
                    ph_next  = MAC_PH_FIRST;
                end
            end
            ST_ROLL_VEC, ST_PITCH_VEC:
            begin
                // Iterate, then start sin/cos of the angle found
                if (cnt_end)
                begin
                    cx_next   = INV_GAIN;
                    cy_next   = '0;
                    cz_next   = sl_z;
                    cneg_next = sl_neg;
                    cnt_next  = '0;
                end
                else
                begin
                    cx_next  = step_x;
                    cy_next  = step_y;
                    cz_next  = step_z;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROLL_ROT, ST_PITCH_ROT:
            begin
                // Iterate, then undo the fold and saturate
                if (cnt_end)
                begin
                    cos_next = sat_q15(cneg_reg ? -cx_reg : cx_reg);
                    sin_next = sat_q15(cneg_reg ? -cy_reg : cy_reg);
                    ph_next  = MAC_PH_FIRST;
                end
                else
                begin
                    cx_next  = step_x;
                    cy_next  = step_y;
                    cz_next  = step_z;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_HEAD_VEC:
            begin
                if (!cnt_end)
                begin
                    cx_next  = step_x;
                    cy_next  = step_y;
                    cz_next  = step_z;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MAC:
            begin
                case (ph_reg)
                    MAC_PH_FIRST:
                    begin
                        prod_next = mul_p;
                        ph_next   = MAC_PH_SECOND;
                    end
                    MAC_PH_SECOND:
                    begin
                        acc_next  = prod_reg;
                        prod_next = mul_p;
                        ph_next   = MAC_PH_SUM;
                    end
                    default:
                    begin
                        // Store the rotated sample, or chain it into the next atan2
                        ph_next  = MAC_PH_FIRST;
                        rot_next = rot_reg + 1'b1;
                        case (rot_reg)
                            ROT_MY2: my2_next = mac_res;
                            ROT_MZ2: mz2_next = mac_res;
                            default:
                            begin
                                cx_next  = vl_x;
                                cy_next  = vl_y;
                                cz_next  = vl_z;
                                cnt_next = vl_cnt;
                            end
                        endcase
                    end
                endcase
            end
            ST_HEADING:
            begin
                head_next = HEADING_W'(h_mod);
            end
            ST_SMOOTH:
            begin
                prev_next = FINE_W'(sm_sum);
            end
            ST_DONE:
            begin
                // Hand the result to the output register once it is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_raw_next   = head_reg;
                    out_fine_next  = prev_reg;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            cnt_reg       <= '0;
            rot_reg       <= ROT_MY2;
            ph_reg        <= MAC_PH_FIRST;
            cneg_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            cnt_reg       <= cnt_next;
            rot_reg       <= rot_next;
            ph_reg        <= ph_next;
            cneg_reg      <= cneg_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        mz_reg   <= mz_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        sin_reg  <= sin_next;
        cos_reg  <= cos_next;
        my2_reg  <= my2_next;
        mz2_reg  <= mz2_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        head_reg <= head_next;
        out_raw_reg  <= out_raw_next;
        out_fine_reg <= out_fine_next;
    end

    // Handshake outputs
    assign sensor.ready                 = (state_reg == ST_IDLE);
    assign result.valid                 = out_valid_reg;
    assign result.raw_heading           = out_raw_reg;
    assign result.smoothed_heading_fine = out_fine_reg;
    assign result.smoothed_heading      = out_fine_reg[FINE_W-1:8];

    // An accepted transaction always starts the roll pass
    a_start_roll: assert property (@(posedge clk) disable iff (!rst_n)
        (sensor.valid && sensor.ready) |=> (state_reg == ST_ROLL_VEC))
        else $error("accepted transaction did not start the roll pass");

    // Smoothed heading never leaves 0..359 degrees
    a_prev_range: assert property (@(posedge clk) disable iff (!rst_n)
        prev_reg <= FINE_W'(FINE_MAX))
        else $error("smoothed heading out of range");

    // Raw heading on the output is wrapped
    a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (out_raw_reg < HEADING_W'(HEADING_MOD)))
        else $error("raw heading not wrapped");

    // Iteration count stays within the step budget
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CORDIC_STEPS))
        else $error("CORDIC step counter overran");

    // A pending result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready && state_reg == ST_DONE) |=> (state_reg == ST_DONE))
        else $error("result overwritten while stalled");

endmodule
